/* rtl/mppc_pkg.sv */
`default_nettype none
package mppc_pkg;

  // Position scale (256 units per degree) as a shift
  localparam int unsigned POS_SHIFT = 8;
  localparam logic signed [63:0] POS_SCALE = 64'sd256;

  // Command codes carried in tuser
  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_ABS  = 2'd1;
  localparam logic [1:0] ACT_REL  = 2'd2;
  localparam logic [1:0] ACT_OFF  = 2'd3;

  // Register indexes
  localparam logic [1:0] REG_ACCEL = 2'd0;
  localparam logic [1:0] REG_SPEED = 2'd1;

  localparam logic [15:0] ACCEL_RST = 16'd64;
  localparam logic [15:0] SPEED_RST = 16'd1024;
  localparam logic [6:0]  PLIM_RST  = 7'd100;

  typedef enum logic [19:0] {
    ST_IDLE = 20'h00001,
    ST_T0   = 20'h00002,
    ST_T1   = 20'h00004,
    ST_T2   = 20'h00008,
    ST_A2   = 20'h00010,
    ST_A3   = 20'h00020,
    ST_A4   = 20'h00040,
    ST_A5   = 20'h00080,
    ST_A6   = 20'h00100,
    ST_P2   = 20'h00200,
    ST_P3   = 20'h00400,
    ST_P4   = 20'h00800,
    ST_P5   = 20'h01000,
    ST_Q1   = 20'h02000,
    ST_F1   = 20'h04000,
    ST_F2   = 20'h08000,
    ST_MUL  = 20'h10000,
    ST_DIV  = 20'h20000,
    ST_FIX  = 20'h40000,
    ST_RPT  = 20'h80000
  } state_t;

  // Request to the shared multiply/divide unit
  typedef struct packed {
    logic              go;
    logic              mul;
    logic signed [63:0] a;
    logic signed [63:0] b;
    state_t            ret;
  } op_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/motor_position_profile_controller.sv */
`default_nettype none
// Trapezoidal position profile controller. Each request is a command: control tick
// (tuser 0, carries the measured tacho count), absolute move (1), relative move (2)
// or switch off (3). Every request yields exactly one status word. Moves, switch off
// and ticks while disabled go from idle straight to the report state, which raises
// the status word. A tick while enabled runs a sequencer around one shared
// bit-serial multiply/divide unit. Each operation consists of an issue, 64 steps and
// a sign fix-up. A tick needs 2 to 7 operations: the fewest when settling near the
// target, more at full power or when braking a reverse motion, and the most when
// decelerating toward the target.
// A new request is taken only once the previous status word has been taken.
// Divisions truncate toward zero; stored 32 bit state saturates. Limit registers are
// to be written through the cfg port while idle (not enforced); zero writes store 1.
module motor_position_profile_controller (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [23:0] position, [31:24] power, [55:32] measured_count
  input  wire logic [55:0] s_axis_tdata,
  // [1:0] action
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] drive_power, [8] power_changed, [9] brake, [10] moving, [11] enabled
  output logic [15:0]      m_axis_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [15:0] cfg_data
);
  import mppc_pkg::*;

  // architectural state
  logic [15:0]        accel_lim, speed_lim;
  logic signed [31:0] tgt, pos_est, vel, acc, err;
  logic               heading_up, ctrl_on, move_act;
  logic signed [7:0]  last_drive, drive_prev;
  logic [6:0]         plim;

  // sequencer and work registers
  state_t             state;
  logic signed [23:0] meas;
  logic               rev;
  logic signed [63:0] w_ax, w_d, w_v, w_p, w_e, w_a, w_k, w_num, w_step, res;

  // shared unit
  logic [63:0] ua, ub, uacc;
  logic        umul, usign;
  logic [5:0]  ucnt;
  state_t      uret;

  logic [15:0] out_word;
  logic        out_valid;

  // input fields
  logic signed [23:0] in_pos;
  logic signed [7:0]  in_pwr;
  logic signed [31:0] in_pos_s;
  logic               accept;

  assign in_pos   = s_axis_tdata[23:0];
  assign in_pwr   = s_axis_tdata[31:24];
  assign in_pos_s = 32'(in_pos) <<< POS_SHIFT;
  assign s_axis_tready = (state == ST_IDLE) && !out_valid;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_word;
  assign cfg_ready = 1'b1;

  // widened operands
  logic signed [63:0] am, vm, ph, ax_c, ex_c, d_c, a_half, stop_c, pe_c;
  logic signed [63:0] a_lo, a_hi, a_a5, tgt_rel;
  logic signed [31:0] tgt_new;
  logic               near_c, done_c;

  always_comb begin
    am     = signed'({48'd0, accel_lim});
    vm     = signed'({48'd0, speed_lim});
    ph     = signed'({57'd0, plim});
    ax_c   = 64'(meas) <<< POS_SHIFT;
    ex_c   = ax_c - 64'(pos_est);
    near_c = (ex_c > -POS_SCALE) && (ex_c < POS_SCALE);
    d_c    = 64'(tgt) - w_ax;
    done_c = heading_up ? (d_c < POS_SCALE) : (d_c > -POS_SCALE);
    a_half = (w_a + signed'({63'd0, w_a[63]})) >>> 1;
    stop_c = w_v + (am >>> 1) + res;
    pe_c   = w_p + w_e;
    // braking while moving backward: a = min(-v, am)
    a_lo   = (-w_v > am) ? am : -w_v;
    // settling: a = clamp(-v, +-am)
    a_hi   = (-w_v < -am) ? -am : ((-w_v > am) ? am : -w_v);
    // deceleration: a = max(-v*v/2d, -v, -am)
    a_a5   = -res;
    if (a_a5 < -w_v) a_a5 = -w_v;
    if (a_a5 < -am)  a_a5 = -am;
    tgt_rel = 64'(tgt) + 64'(in_pos_s);
    tgt_new = (s_axis_tuser == ACT_ABS) ? in_pos_s : sat32(tgt_rel);
  end

  // operation requests per sequencer step
  op_req_t req;
  always_comb begin
    req = '0;
    req.ret = ST_IDLE;
    case (state)
      ST_T2: begin
        req.go = 1'b1;
        req.mul = 1'b1;
        if (w_d >= POS_SCALE && w_v >= 0) begin
          req.a = w_v; req.b = w_v; req.ret = ST_A2;
        end else if (w_d >= POS_SCALE) begin
          req.a = ph; req.b = a_lo; req.ret = ST_P2;
        end else begin
          req.a = ph; req.b = a_hi; req.ret = ST_Q1;
        end
      end
      ST_A2: begin
        req.go = 1'b1; req.a = res; req.b = am <<< 1; req.ret = ST_A3;
      end
      ST_A3: begin
        req.go = 1'b1;
        if (w_d >= stop_c) begin
          req.mul = 1'b1; req.a = am; req.b = vm - w_v; req.ret = ST_A4;
        end else begin
          req.a = w_num; req.b = w_d <<< 1; req.ret = ST_A5;
        end
      end
      ST_A4: begin
        req.go = 1'b1; req.a = res; req.b = vm; req.ret = ST_A6;
      end
      ST_A5: begin
        req.go = 1'b1; req.mul = 1'b1; req.a = ph; req.b = a_a5; req.ret = ST_P2;
      end
      ST_P2: begin
        req.go = 1'b1; req.mul = 1'b1; req.a = res; req.b = w_k; req.ret = ST_P3;
      end
      ST_P3: begin
        req.go = 1'b1; req.mul = 1'b1; req.a = am; req.b = vm; req.ret = ST_P4;
      end
      ST_P4: begin
        req.go = 1'b1; req.a = w_num; req.b = res; req.ret = ST_P5;
      end
      ST_Q1: begin
        req.go = 1'b1; req.a = res; req.b = am; req.ret = ST_P5;
      end
      default: ;
    endcase
  end

  // divide step
  logic [64:0] rsh;
  logic        rge;
  logic [63:0] uval;
  assign rsh  = {uacc, ua[63]};
  assign rge  = rsh >= {1'b0, ub};
  assign uval = umul ? uacc : ua;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_lim  <= ACCEL_RST;
      speed_lim  <= SPEED_RST;
      tgt        <= '0;
      pos_est    <= '0;
      vel        <= '0;
      acc        <= '0;
      err        <= '0;
      heading_up <= 1'b0;
      ctrl_on    <= 1'b0;
      move_act   <= 1'b0;
      last_drive <= '0;
      plim       <= PLIM_RST;
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_addr == REG_ACCEL) accel_lim <= (cfg_data == 16'd0) ? 16'd1 : cfg_data;
        if (cfg_addr == REG_SPEED) speed_lim <= (cfg_data == 16'd0) ? 16'd1 : cfg_data;
      end
      if (out_valid && m_axis_tready) out_valid <= 1'b0;

      if (req.go) begin
        ua    <= req.a[63] ? 64'(-req.a) : 64'(req.a);
        ub    <= req.b[63] ? 64'(-req.b) : 64'(req.b);
        uacc  <= '0;
        usign <= req.a[63] ^ req.b[63];
        umul  <= req.mul;
        ucnt  <= 6'd63;
        uret  <= req.ret;
        state <= req.mul ? ST_MUL : ST_DIV;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            drive_prev <= last_drive;
            meas       <= s_axis_tdata[55:32];
            state      <= ST_RPT;
            unique case (s_axis_tuser) inside
              ACT_ABS, ACT_REL: begin
                if (in_pwr > 0) plim <= in_pwr[6:0];
                if (in_pwr > 0 || s_axis_tuser == ACT_REL) begin
                  tgt        <= tgt_new;
                  heading_up <= tgt_new > pos_est;
                  ctrl_on    <= 1'b1;
                  move_act   <= 1'b1;
                end
              end
              ACT_OFF: begin
                if (ctrl_on) begin
                  move_act   <= 1'b0;
                  last_drive <= '0;
                  ctrl_on    <= 1'b0;
                  vel        <= '0;
                  acc        <= '0;
                end
              end
              ACT_TICK: begin
                if (ctrl_on) state <= ST_T0;
              end
              default: ;
            endcase
          end
        end
        ST_T0: begin
          // small tacho error: trust the estimate
          w_ax  <= near_c ? 64'(pos_est) : ax_c;
          w_e   <= (!near_c && move_act) ? 64'(err) - ex_c : 64'sd0;
          state <= ST_T1;
        end
        ST_T1: begin
          if (done_c) move_act <= 1'b0;
          rev   <= d_c < 0;
          w_d   <= (d_c < 0) ? -d_c : d_c;
          w_v   <= (d_c < 0) ? -64'(vel) : 64'(vel);
          w_p   <= (d_c < 0) ? -64'(last_drive) : 64'(last_drive);
          w_e   <= done_c ? 64'sd0 : ((d_c < 0) ? -w_e : w_e);
          state <= ST_T2;
        end
        ST_T2: begin
          // far: cruise or brake; near: settle
          if (w_d >= POS_SCALE && w_v < 0) begin
            w_a <= a_lo;
            w_k <= vm + w_v;
          end else if (w_d < POS_SCALE) begin
            w_a <= a_hi;
          end
        end
        ST_A2: w_num <= res;
        ST_A3: begin
          if (w_d >= stop_c) begin
            w_p <= ph;
            w_e <= '0;
          end
        end
        ST_A4: ;
        ST_A5: begin
          w_a <= a_a5;
          w_k <= vm - w_v;
        end
        ST_A6: begin
          w_a   <= res;
          state <= ST_F1;
        end
        ST_P2: ;
        ST_P3: w_num <= res;
        ST_P4: ;
        ST_Q1: ;
        ST_P5: begin
          w_p   <= res;
          state <= ST_F1;
        end
        ST_F1: begin
          w_step <= w_v + a_half;
          w_v    <= w_v + w_a;
          if (pe_c > ph) begin
            w_p <= ph;
            w_e <= '0;
          end else if (pe_c < -ph) begin
            w_p <= -ph;
            w_e <= '0;
          end else begin
            w_p <= pe_c;
          end
          state <= ST_F2;
        end
        ST_F2: begin
          last_drive <= rev ? 8'(-w_p) : 8'(w_p);
          pos_est    <= sat32(w_ax + (rev ? -w_step : w_step));
          vel        <= sat32(rev ? -w_v : w_v);
          acc        <= sat32(rev ? -w_a : w_a);
          err        <= sat32(rev ? -w_e : w_e);
          state      <= ST_RPT;
        end
        ST_MUL: begin
          if (ub[0]) uacc <= uacc + ua;
          ua   <= ua << 1;
          ub   <= ub >> 1;
          ucnt <= ucnt - 6'd1;
          if (ucnt == 6'd0) state <= ST_FIX;
        end
        ST_DIV: begin
          uacc <= rge ? 64'(rsh - {1'b0, ub}) : rsh[63:0];
          ua   <= {ua[62:0], rge};
          ucnt <= ucnt - 6'd1;
          if (ucnt == 6'd0) state <= ST_FIX;
        end
        ST_FIX: begin
          res   <= usign ? -signed'(uval) : signed'(uval);
          state <= uret;
        end
        ST_RPT: begin
          out_word  <= {4'd0, ctrl_on, move_act, last_drive == 8'sd0,
                        last_drive != drive_prev, last_drive};
          out_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/mppc_chk.sv */
`default_nettype none
module mppc_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);
  // one request in flight: no new request while a status word waits
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("request taken while output pending");

  a_brake: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[9] == (m_axis_tdata[7:0] == 8'h00)))
    else $error("brake flag disagrees with drive");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[7:0] != 8'h80)) else $error("drive out of range");

  a_off: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[11]) |->
      (m_axis_tdata[7:0] == 8'h00 && !m_axis_tdata[10]))
    else $error("drive or motion while disabled");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output changed");
endmodule

bind motor_position_profile_controller mppc_chk u_mppc_chk (
  .clk(clk), .rst(rst), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

/* bench/motor_position_profile_checker.sv */
`default_nettype none
module motor_position_profile_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,
  input  wire logic [1:0]  s_axis_tuser,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [15:0] m_axis_tdata,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [15:0] cfg_data,
  output int               errors,
  output int               pending,
  output longint           est_deg
);
  import mppc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [7:0] drive;
    logic              changed;
    logic              brake;
    logic              moving;
    logic              enabled;
  } status_t;

  status_t status_q[$];

  longint accel_max, speed_max, plim;
  longint tgt, est, vel, acc, drv, corr;
  bit     up, on, mv;

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic profile_tick(input longint cnt);
    longint s, x, v, a, p, am, vm, ph, e, ax, ex, d, step, stop;
    bit rev;
    s = POS_SCALE; x = est; v = vel; p = drv; am = accel_max; vm = speed_max;
    ph = plim; e = 0; ax = s * cnt; rev = 0; a = 0;
    ex = ax - x;
    if (-s < ex && ex < s) ax = x;
    else if (mv) e = corr - ex;
    d = tgt - ax;
    if (up ? (d < s) : (d > -s)) begin
      mv = 0;
      e = 0;
    end
    if (d < 0) begin
      d = -d; v = -v; p = -p; e = -e; rev = 1;
    end
    if (d >= s) begin
      if (v >= 0) begin
        stop = (v + am / 2) + (v * v) / (2 * am);
        if (d >= stop) begin
          p = ph;
          a = (am * (vm - v)) / vm;
          e = 0;
        end else begin
          a = -((v * v) / (2 * d));
          if (a < -v) a = -v;
          if (a < -am) a = -am;
          p = (ph * a * (vm - v)) / (am * vm);
        end
      end else begin
        a = -v;
        if (a > am) a = am;
        p = (ph * a * (vm + v)) / (am * vm);
      end
    end else begin
      a = -v;
      if (a < -am) a = -am;
      else if (a > am) a = am;
      p = (ph * a) / am;
    end
    step = v + a / 2;
    v = v + a;
    p = p + e;
    if (p > ph) begin
      p = ph; e = 0;
    end else if (p < -ph) begin
      p = -ph; e = 0;
    end
    if (rev) begin
      step = -step; v = -v; a = -a; p = -p; e = -e;
    end
    drv = p;
    est = clamp32(ax + step);
    vel = clamp32(v);
    acc = clamp32(a);
    corr = clamp32(e);
  endtask

  task automatic apply_cmd(input logic [1:0] act, input logic [55:0] data);
    longint pos, pwr, cnt, prev;
    status_t st;
    pos = longint'(signed'(data[23:0]));
    pwr = longint'(signed'(data[31:24]));
    cnt = longint'(signed'(data[55:32]));
    prev = drv;
    case (act)
      ACT_ABS: begin
        if (pwr > 0) begin
          plim = pwr;
          tgt = clamp32(POS_SCALE * pos);
          up = tgt > est; on = 1; mv = 1;
        end
      end
      ACT_REL: begin
        if (pwr > 0) plim = pwr;
        tgt = clamp32(tgt + POS_SCALE * pos);
        up = tgt > est; on = 1; mv = 1;
      end
      ACT_OFF: begin
        if (on) begin
          mv = 0; drv = 0; on = 0; vel = 0; acc = 0;
        end
      end
      default: begin
        if (on) profile_tick(cnt);
      end
    endcase
    st.drive = drv[7:0];
    st.changed = drv != prev;
    st.brake = drv == 0;
    st.moving = mv;
    st.enabled = on;
    status_q.push_back(st);
  endtask

  assign pending = status_q.size();
  assign est_deg = est / POS_SCALE;

  always @(posedge clk) begin
    status_t got, exp_st;
    if (rst) begin
      accel_max = ACCEL_RST; speed_max = SPEED_RST; plim = PLIM_RST;
      tgt = 0; est = 0; vel = 0; acc = 0; drv = 0; corr = 0;
      up = 0; on = 0; mv = 0;
      errors = 0;
      status_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        // zero write lands as 1, unknown index dropped
        if (cfg_addr == REG_ACCEL)
          accel_max = (cfg_data == 16'd0) ? 64'sd1 : longint'(cfg_data);
        else if (cfg_addr == REG_SPEED)
          speed_max = (cfg_data == 16'd0) ? 64'sd1 : longint'(cfg_data);
      end
      if (s_axis_tvalid && s_axis_tready) apply_cmd(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[7:0], m_axis_tdata[8], m_axis_tdata[9], m_axis_tdata[10],
               m_axis_tdata[11]};
        if (status_q.size() == 0) begin
          errors = errors + 1;
          $display("%0t: unexpected status, got drive %0d chg %b brk %b mov %b en %b",
                   $time, got.drive, got.changed, got.brake, got.moving, got.enabled);
        end else begin
          exp_st = status_q.pop_front();
          if (got !== exp_st) begin
            errors = errors + 1;
            $display("%0t: status mismatch exp drive %0d chg %b brk %b mov %b en %b",
                     $time, exp_st.drive, exp_st.changed, exp_st.brake, exp_st.moving,
                     exp_st.enabled);
            $display("%0t:                 got drive %0d chg %b brk %b mov %b en %b",
                     $time, got.drive, got.changed, got.brake, got.moving, got.enabled);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

/* bench/motor_position_profile_controller_tb.sv */
`default_nettype none
module motor_position_profile_controller_tb;
  import mppc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 20000;  // covers the slowest tick plus long stalls

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;   // [23:0] position, [31:24] power, [55:32] measured_count
  logic [1:0]  s_axis_tuser;   // [1:0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [7:0] drive, [8] changed, [9] brake, [10] moving, [11] enabled
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_addr;
  logic [15:0] cfg_data;

  int     errors;
  int     pending;
  longint est_deg;
  int     burst_left;
  int     quiet;
  int     rdy_mode;

  motor_position_profile_controller u_top (.*);

  motor_position_profile_checker u_chk (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_valid, .cfg_ready,
    .cfg_addr, .cfg_data, .errors, .pending, .est_deg
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Receiver: stall pattern switches every so often between
  // always ready, coin flip, and mostly stalled.
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) rdy_mode = $urandom_range(0, 2);
    case (rdy_mode)
      0: m_axis_tready = 1;
      1: m_axis_tready = $urandom_range(0, 1);
      default: m_axis_tready = ($urandom_range(0, 7) == 0);
    endcase
  end

  // Watchdog: any accepted request, status or register write clears it
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("** motor_position_profile_controller: FAILED **");
        $finish;
      end
    end
  end

  function automatic int clip24(input longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return int'(v);
  endfunction

  // One command request; sender runs in bursts with random gaps
  task automatic send_cmd(input logic [1:0] act, input int pos, input int pwr,
                          input int cnt);
    if (burst_left == 0) begin
      s_axis_tvalid = 0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50)
                                                : $urandom_range(1, 12);
    end
    s_axis_tuser = act;
    s_axis_tdata = {cnt[23:0], pwr[7:0], pos[23:0]};
    s_axis_tvalid = 1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    burst_left--;
  endtask

  // Hold off until every status has come back
  task automatic drain();
    s_axis_tvalid = 0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_addr = idx;
    cfg_data = val;
    cfg_valid = 1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  // Tick with a count that follows the estimate, small tracking error
  task automatic track_tick();
    send_cmd(ACT_TICK, 0, 0, clip24(est_deg + $urandom_range(0, 6) - 3));
  endtask

  // Move then follow it for a while, with some noise and interruptions
  task automatic move_run();
    int n, k, span, pw;
    span = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 32'hffffff)
                                        : $urandom_range(0, 600) - 300;
    pw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 100);
    if ($urandom_range(0, 2) == 0)
      send_cmd(ACT_REL, span, pw, $urandom);
    else
      send_cmd(ACT_ABS, clip24(est_deg + (($urandom_range(0, 15) == 0) ? span : span)),
               pw, $urandom);
    n = $urandom_range(5, 40);
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 19))
        0: send_cmd(ACT_TICK, $urandom, $urandom, $urandom);
        1: send_cmd(ACT_TICK, 0, 0, clip24(est_deg + $urandom_range(0, 400) - 200));
        2: send_cmd(ACT_REL, $urandom_range(0, 100) - 50, $urandom_range(0, 255), 0);
        3: if ($urandom_range(0, 3) == 0) send_cmd(ACT_OFF, $urandom, $urandom, $urandom);
           else track_tick();
        default: track_tick();
      endcase
    end
  endtask

  initial begin
    int ph, sent;
    logic [15:0] acc_v[6];
    logic [15:0] spd_v[6];
    acc_v = '{16'd1, 16'd65535, 16'd0, 16'd64, 16'd200, 16'd7};
    spd_v = '{16'd1, 16'd65535, 16'd0, 16'd1024, 16'd3000, 16'd40000};
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tuser = ACT_TICK;
    cfg_valid = 0;
    cfg_addr = REG_ACCEL;
    cfg_data = '0;
    burst_left = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: idle commands, ignored moves, extremes
    send_cmd(ACT_TICK, 0, 0, 8388607);               // tick while off
    send_cmd(ACT_OFF, 0, 0, 0);                      // off while off
    send_cmd(ACT_ABS, 1000, 0, 0);                   // ignored, power zero
    send_cmd(ACT_ABS, -1000, -128, 0);               // ignored, negative power
    send_cmd(ACT_REL, 50, 0, 0);                     // moves, limit kept
    send_cmd(ACT_TICK, 0, 0, 0);
    send_cmd(ACT_TICK, 0, 0, 5);
    send_cmd(ACT_ABS, 8388607, 127, 0);              // far target, top power
    send_cmd(ACT_TICK, 0, 0, 0);
    send_cmd(ACT_TICK, 0, 0, -8388608);              // wild count
    send_cmd(ACT_TICK, 0, 0, 8388607);
    send_cmd(ACT_REL, 8388607, 100, 0);              // target saturates
    send_cmd(ACT_TICK, 0, 0, 8388607);
    send_cmd(ACT_OFF, 0, 0, 0);
    send_cmd(ACT_ABS, -8388608, 1, 0);
    send_cmd(ACT_TICK, 0, 0, -8388608);
    send_cmd(ACT_REL, -8388608, 100, 0);
    send_cmd(ACT_TICK, 0, 0, -8388608);
    send_cmd(ACT_TICK, 0, 0, -8388608);
    send_cmd(ACT_ABS, 0, 100, 0);
    send_cmd(ACT_TICK, 0, 0, 0);                     // inside one unit
    send_cmd(ACT_OFF, 0, 0, 0);
    drain();

    // Unknown indexes are dropped
    write_reg(2'd2, 16'hffff);
    write_reg(2'd3, 16'h0000);

    for (ph = 0; ph < 6; ph++) begin
      write_reg(REG_ACCEL, acc_v[ph]);
      write_reg(REG_SPEED, spd_v[ph]);
      if (ph == 5) begin
        write_reg(REG_ACCEL, 16'($urandom));
        write_reg(REG_SPEED, 16'($urandom));
      end
      sent = 0;
      while (sent < 115) begin
        move_run();
        sent += 25;
      end
      drain();
    end

    drain();
    repeat (300) @(negedge clk);
    if (errors == 0) begin
      $display("** motor_position_profile_controller: PASSED **");
    end else begin
      $display("** motor_position_profile_controller: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
